>>> hw/rtl/blte_pkg.sv
// ============================================================================
// blte_pkg: shared types and constants for the bounded list table engine
// Holds capacity, field widths, request codes, sentinels and the
// sequencer state type.
// ============================================================================
package blte_pkg;

   localparam int CAPACITY   = 16;
   localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W      = 5;
   localparam int LVL_W      = $clog2(CAPACITY + 1);
   localparam int DATA_W     = 32;
   localparam int SUM_W      = 36;

   localparam logic signed [DATA_W-1:0] EMPTY_MAX = -32'sd999;
   localparam logic signed [DATA_W-1:0] EMPTY_MIN = 32'sd9999999;
   localparam logic signed [DATA_W-1:0] NO_MODE   = -32'sd999;

   localparam logic [2:0] REQ_CLEAR     = 3'd0;
   localparam logic [2:0] REQ_APPEND    = 3'd1;
   localparam logic [2:0] REQ_DEL_FIRST = 3'd2;
   localparam logic [2:0] REQ_DEL_ALL   = 3'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DEL_RD,
      ST_DEL_WR,
      ST_SCAN_RD,
      ST_OUTER,
      ST_INNER_RD,
      ST_INNER,
      ST_DIV,
      ST_DONE
   } state_type;

   // divider control between sequencer and divide unit
   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

>>> hw/rtl/blte_ram.sv
// ============================================================================
// blte_ram: generic single-port RAM
// One access per cycle, registered read data (the old word on a write).
// ============================================================================
module blte_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write or read the addressed word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end

endmodule

>>> hw/rtl/blte_div.sv
// ============================================================================
// blte_div: serial signed divider
// Restoring division of the sum by the fill level, one quotient bit per
// cycle, quotient truncated toward zero.
// ============================================================================
module blte_div import blte_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  div_ctl_type              ctl,
   input  logic signed [SUM_W-1:0]  dividend,
   input  logic [LVL_W-1:0]         divisor,
   output div_sts_type              sts,
   output logic signed [DATA_W-1:0] quotient
);

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [LVL_W:0]    rem_ff, rem_in;
   logic [LVL_W-1:0]  dvs_ff, dvs_in;
   logic              neg_ff, neg_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [LVL_W:0]    trial;
   logic [SUM_W-1:0]  signed_q;

   // shift in one dividend bit and try a subtract
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[LVL_W-1:0], quo_ff[SUM_W-1]};
      if (ctl.start) begin
         neg_in  = dividend[SUM_W-1];
         quo_in  = dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         step_in = STEP_W'(SUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
      step_ff <= step_in;
   end

   assign signed_q = neg_ff ? SUM_W'(-quo_ff) : quo_ff;
   assign quotient = signed_q[DATA_W-1:0];
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule

>>> hw/rtl/bounded_list_table_engine.sv
// Sequence: each request runs a pairwise count loop over the N entries in the
// single-port entry RAM, then the 36-step serial divide; a delete first reads
// and compacts every entry. An empty list skips the loop and the divide.
// Throughput: one request at a time; req_ready is low until the result
// transfer. Reset clears fill level and sequencer; entries stay undefined.
// ============================================================================
// bounded_list_table_engine: packed list with search and statistics
// Sequencer over one entry RAM, one shared comparator path and a serial
// divider.
// ============================================================================
module bounded_list_table_engine import blte_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [2:0]               req_type,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [CNT_W-1:0]         rsp_position,
   output logic [CNT_W-1:0]         rsp_match_count,
   output logic [CNT_W-1:0]         rsp_entry_count,
   output logic signed [SUM_W-1:0]  rsp_total,
   output logic signed [DATA_W-1:0] rsp_mean,
   output logic signed [DATA_W-1:0] rsp_largest,
   output logic signed [DATA_W-1:0] rsp_smallest,
   output logic signed [DATA_W-1:0] rsp_most_frequent,
   output logic                     rsp_is_full,
   output logic                     rsp_is_empty,
   output logic                     rsp_rejected
);

   state_type state_ff, state_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in;
   logic [2:0]       op_ff, op_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic [LVL_W-1:0] rd_ff, rd_in;       // read / outer index
   logic [LVL_W-1:0] wr_ff, wr_in;       // write / inner index
   logic             found_ff, found_in;
   logic signed [DATA_W-1:0] ent_ff, ent_in;   // outer element
   logic [LVL_W-1:0] cnt_ff, cnt_in;     // inner match count
   logic [LVL_W-1:0] best_ff, best_in;
   logic [LVL_W-1:0] pos_ff, pos_in;
   logic [LVL_W-1:0] mcnt_ff, mcnt_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [DATA_W-1:0] mx_ff, mx_in, mn_ff, mn_in, mode_ff, mode_in;
   logic signed [DATA_W-1:0] mean_ff, mean_in;
   logic             rej_ff, rej_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             ram_we;
   logic [IDX_W-1:0] ram_addr;
   logic [DATA_W-1:0] ram_wd, ram_rd;
   logic signed [DATA_W-1:0] rd_s;
   logic             eq_hit;
   div_ctl_type      div_ctl;
   div_sts_type      div_sts;
   logic signed [DATA_W-1:0] div_q;

   blte_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram (
      .clock, .wr_en(ram_we), .addr(ram_addr), .wr_data(ram_wd), .rd_data(ram_rd)
   );

   blte_div u_div (
      .clock, .reset, .ctl(div_ctl), .dividend(sum_ff), .divisor(lvl_ff),
      .sts(div_sts), .quotient(div_q)
   );

   assign rd_s = $signed(ram_rd);
   // shared comparator: RAM word against the key of the current phase
   assign eq_hit = (rd_s == ((state_ff == ST_INNER) ? ent_ff : val_ff));

   // sequence the request
   always_comb begin
      state_in = state_ff;
      lvl_in = lvl_ff;   op_in = op_ff;     val_in = val_ff;
      rd_in = rd_ff;     wr_in = wr_ff;     found_in = found_ff;
      ent_in = ent_ff;   cnt_in = cnt_ff;   best_in = best_ff;
      pos_in = pos_ff;   mcnt_in = mcnt_ff; sum_in = sum_ff;
      mx_in = mx_ff;     mn_in = mn_ff;     mode_in = mode_ff;
      mean_in = mean_ff; rej_in = rej_ff;   rsp_valid_in = rsp_valid_ff;
      ram_we = 1'b0;
      ram_addr = rd_ff[IDX_W-1:0];
      ram_wd = val_ff;
      div_ctl.start = 1'b0;
      req_ready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in = req_type; val_in = req_value; rej_in = 1'b0;
               rd_in = '0; wr_in = '0; found_in = 1'b0;
               state_in = ST_SCAN_RD;
               case (req_type)
                  REQ_CLEAR: lvl_in = '0;
                  REQ_APPEND: begin
                     if (lvl_ff < LVL_W'(CAPACITY)) begin
                        ram_we = 1'b1;
                        ram_addr = lvl_ff[IDX_W-1:0];
                        ram_wd = req_value;
                        lvl_in = lvl_ff + 1'b1;
                     end else begin
                        rej_in = 1'b1;
                     end
                  end
                  REQ_DEL_FIRST, REQ_DEL_ALL: state_in = ST_DEL_RD;
                  default: ;
               endcase
            end
         end
         // issue a read of entry rd
         ST_DEL_RD: begin
            if (rd_ff == lvl_ff) begin
               lvl_in = wr_ff; rd_in = '0; state_in = ST_SCAN_RD;
            end else begin
               state_in = ST_DEL_WR;
            end
         end
         // drop the first match (delete-first) or every match, compact survivors to wr
         ST_DEL_WR: begin
            if (eq_hit && !(op_ff == REQ_DEL_FIRST && found_ff)) begin
               found_in = 1'b1;
            end else begin
               ram_we = 1'b1;
               ram_addr = wr_ff[IDX_W-1:0];
               ram_wd = ram_rd;
               wr_in = wr_ff + 1'b1;
            end
            rd_in = rd_ff + 1'b1;
            state_in = ST_DEL_RD;
         end
         ST_SCAN_RD: begin
            rd_in = '0; sum_in = '0; mx_in = EMPTY_MAX; mn_in = EMPTY_MIN;
            mode_in = NO_MODE; best_in = '0; pos_in = '0; mcnt_in = '0;
            state_in = (lvl_ff == '0) ? ST_DIV : ST_OUTER;
            ram_addr = '0;
         end
         // outer element is on the read port
         ST_OUTER: begin
            ent_in = rd_s;
            sum_in = sum_ff + SUM_W'(rd_s);
            if (rd_s > mx_ff) mx_in = rd_s;
            if (rd_s < mn_ff) mn_in = rd_s;
            if (eq_hit) begin
               if (pos_ff == '0) pos_in = rd_ff + 1'b1;
               mcnt_in = mcnt_ff + 1'b1;
            end
            wr_in = '0; cnt_in = '0;
            state_in = ST_INNER_RD;
         end
         ST_INNER_RD: begin
            ram_addr = wr_ff[IDX_W-1:0];
            state_in = ST_INNER;
         end
         // count copies of the outer element
         ST_INNER: begin
            cnt_in = cnt_ff + LVL_W'(eq_hit);
            if (wr_ff + 1'b1 == lvl_ff) begin
               if (cnt_in > best_ff) begin
                  best_in = cnt_in; mode_in = ent_ff;
               end
               rd_in = rd_ff + 1'b1;
               ram_addr = rd_in[IDX_W-1:0];
               if (rd_in == lvl_ff) begin
                  state_in = ST_DIV; div_ctl.start = 1'b1;
               end else begin
                  state_in = ST_OUTER;
               end
            end else begin
               wr_in = wr_ff + 1'b1;
               state_in = ST_INNER_RD;
            end
         end
         ST_DIV: begin
            if (lvl_ff == '0) begin
               mean_in = '0; state_in = ST_DONE; rsp_valid_in = 1'b1;
            end else if (div_sts.done) begin
               mean_in = div_q; state_in = ST_DONE; rsp_valid_in = 1'b1;
            end
         end
         ST_DONE: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0; state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lvl_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         lvl_ff <= lvl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in;     val_ff <= val_in;   rd_ff <= rd_in;
      wr_ff <= wr_in;     found_ff <= found_in; ent_ff <= ent_in;
      cnt_ff <= cnt_in;   best_ff <= best_in; pos_ff <= pos_in;
      mcnt_ff <= mcnt_in; sum_ff <= sum_in;   mx_ff <= mx_in;
      mn_ff <= mn_in;     mode_ff <= mode_in; mean_ff <= mean_in;
      rej_ff <= rej_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_position      = CNT_W'(pos_ff);
   assign rsp_match_count   = CNT_W'(mcnt_ff);
   assign rsp_entry_count   = CNT_W'(lvl_ff);
   assign rsp_total         = sum_ff;
   assign rsp_mean          = mean_ff;
   assign rsp_largest       = mx_ff;
   assign rsp_smallest      = mn_ff;
   assign rsp_most_frequent = mode_ff;
   assign rsp_is_full       = (lvl_ff == LVL_W'(CAPACITY));
   assign rsp_is_empty      = (lvl_ff == '0);
   assign rsp_rejected      = rej_ff;

`ifndef SYNTHESIS
   a_lvl_bound: assert property (@(posedge clock) disable iff (reset)
      lvl_ff <= LVL_W'(CAPACITY)) else $error("fill level above capacity");
   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_total))
      else $error("result changed while stalled");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> mcnt_ff <= lvl_ff) else $error("match count above fill");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !div_sts.busy) else $error("divider busy while idle");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking bench for the bounded list table engine
// Drives clear, append, delete-first, delete-all, query and reserved-code requests
// through the request channel, predicts every response from a local list model and
// compares each response field by field, with random idling on both sides.
// ============================================================================
module tb;
   import blte_pkg::*;

   typedef struct packed {
      logic [CNT_W-1:0]         position;
      logic [CNT_W-1:0]         match_count;
      logic [CNT_W-1:0]         entry_count;
      logic signed [SUM_W-1:0]  total;
      logic signed [DATA_W-1:0] mean;
      logic signed [DATA_W-1:0] largest;
      logic signed [DATA_W-1:0] smallest;
      logic signed [DATA_W-1:0] most_frequent;
      logic                     is_full;
      logic                     is_empty;
      logic                     rejected;
   } list_stats_type;

   localparam logic [2:0] REQ_QUERY  = 3'd4;
   localparam logic [2:0] REQ_RSVD_5 = 3'd5;
   localparam logic [2:0] REQ_RSVD_6 = 3'd6;
   localparam logic [2:0] REQ_RSVD_7 = 3'd7;
   localparam int RANDOM_ITEMS = 1830;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [2:0]               req_type = REQ_QUERY;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   list_stats_type           got;

   bounded_list_table_engine dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_type(req_type), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_position(got.position), .rsp_match_count(got.match_count),
      .rsp_entry_count(got.entry_count), .rsp_total(got.total),
      .rsp_mean(got.mean), .rsp_largest(got.largest),
      .rsp_smallest(got.smallest), .rsp_most_frequent(got.most_frequent),
      .rsp_is_full(got.is_full), .rsp_is_empty(got.is_empty),
      .rsp_rejected(got.rejected)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // local copy of the list
   logic signed [DATA_W-1:0] shadow_list [CAPACITY];
   int                       shadow_fill;
   list_stats_type           expected_stats [$];
   int                       error_count;
   int                       rsp_seen;
   int                       reject_seen;
   int                       full_seen;

   task automatic report_mismatch(input string what, input longint g, input longint e);
      $display("MISMATCH at response %0d: %s got %0d expected %0d", rsp_seen, what, g, e);
      error_count++;
   endtask

   // apply one request to the local list and compute its response
   function automatic list_stats_type predict_stats(input logic [2:0] op,
                                                    input logic signed [DATA_W-1:0] v);
      list_stats_type s;
      int i, j, w, c, best, pos, cnt;
      logic signed [SUM_W-1:0] sum;
      logic signed [DATA_W-1:0] e;
      s = '0;
      case (op)
         REQ_CLEAR: shadow_fill = 0;
         REQ_APPEND: begin
            if (shadow_fill < CAPACITY) begin
               shadow_list[shadow_fill] = v;
               shadow_fill++;
            end else s.rejected = 1'b1;
         end
         REQ_DEL_FIRST: begin
            i = 0;
            while (i < shadow_fill && shadow_list[i] != v) i++;
            if (i < shadow_fill) begin
               for (; i + 1 < shadow_fill; i++) shadow_list[i] = shadow_list[i+1];
               shadow_fill--;
            end
         end
         REQ_DEL_ALL: begin
            w = 0;
            for (i = 0; i < shadow_fill; i++)
               if (shadow_list[i] != v) begin
                  shadow_list[w] = shadow_list[i];
                  w++;
               end
            shadow_fill = w;
         end
         default: ;
      endcase
      sum = '0; pos = 0; cnt = 0; best = 0;
      s.largest = EMPTY_MAX; s.smallest = EMPTY_MIN; s.most_frequent = NO_MODE;
      for (i = 0; i < shadow_fill; i++) begin
         e = shadow_list[i];
         if (e == v) begin
            if (pos == 0) pos = i + 1;
            cnt++;
         end
         sum += e;
         if (e > s.largest) s.largest = e;
         if (e < s.smallest) s.smallest = e;
         c = 0;
         for (j = 0; j < shadow_fill; j++) if (shadow_list[j] == e) c++;
         if (c > best) begin
            best = c;
            s.most_frequent = e;
         end
      end
      s.position = CNT_W'(pos);
      s.match_count = CNT_W'(cnt);
      s.entry_count = CNT_W'(shadow_fill);
      s.total = sum;
      s.mean = (shadow_fill > 0) ? DATA_W'(sum / shadow_fill) : '0;
      s.is_full = (shadow_fill == CAPACITY);
      s.is_empty = (shadow_fill == 0);
      return s;
   endfunction

   function automatic int short_gap();
      return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) :
             ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
   endfunction

   // drive one request and wait for its transfer
   task automatic send_request(input logic [2:0] op, input logic signed [DATA_W-1:0] v,
                               input bit idle_ok);
      int gap;
      gap = idle_ok ? short_gap() : 0;
      repeat (gap + 1) @(negedge clock);
      req_type  <= op;
      req_value <= v;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_stats.push_back(predict_stats(op, v));
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return (32'sh7fffffff - $urandom_range(0, 2));
         2: return (32'sh80000000 + $urandom_range(0, 2));
         3: return EMPTY_MAX;
         default: return $signed($urandom_range(0, 6)) - 3;
      endcase
   endfunction

   // response side: random stall, compare on transfer
   initial begin : rsp_side
      list_stats_type want;
      error_count = 0; rsp_seen = 0; reject_seen = 0; full_seen = 0;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(0, 24) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (expected_stats.size() == 0) begin
               $display("MISMATCH: response %0d with nothing outstanding", rsp_seen);
               error_count++;
            end else begin
               want = expected_stats.pop_front();
               if (got.position != want.position)
                  report_mismatch("position", got.position, want.position);
               if (got.match_count != want.match_count)
                  report_mismatch("match_count", got.match_count, want.match_count);
               if (got.entry_count != want.entry_count)
                  report_mismatch("entry_count", got.entry_count, want.entry_count);
               if (got.total !== want.total) report_mismatch("total", got.total, want.total);
               if (got.mean !== want.mean) report_mismatch("mean", got.mean, want.mean);
               if (got.largest !== want.largest)
                  report_mismatch("largest", got.largest, want.largest);
               if (got.smallest !== want.smallest)
                  report_mismatch("smallest", got.smallest, want.smallest);
               if (got.most_frequent !== want.most_frequent)
                  report_mismatch("most_frequent", got.most_frequent, want.most_frequent);
               if (got.is_full !== want.is_full)
                  report_mismatch("is_full", got.is_full, want.is_full);
               if (got.is_empty !== want.is_empty)
                  report_mismatch("is_empty", got.is_empty, want.is_empty);
               if (got.rejected !== want.rejected)
                  report_mismatch("rejected", got.rejected, want.rejected);
               if (want.rejected) reject_seen++;
               if (want.is_full) full_seen++;
            end
            rsp_seen++;
         end
      end
   end

   // directed rows: op, value, and a fixed check where obvious
   typedef struct {
      logic [2:0]               op;
      logic signed [DATA_W-1:0] v;
      bit                       check_empty;
   } stim_row_type;

   stim_row_type directed_rows [] = '{
      '{REQ_QUERY,     32'sd5,          1'b1},
      '{REQ_RSVD_5,    32'sd0,          1'b1},
      '{REQ_DEL_FIRST, 32'sd1,          1'b1},
      '{REQ_DEL_ALL,   32'sd1,          1'b1},
      '{REQ_APPEND,    32'sh7fffffff,   1'b0},
      '{REQ_APPEND,    32'sh80000000,   1'b0},
      '{REQ_APPEND,    -32'sd999,       1'b0},
      '{REQ_APPEND,    32'sd9999999,    1'b0},
      '{REQ_APPEND,    32'sd10000000,   1'b0},
      '{REQ_APPEND,    -32'sd1000,      1'b0},
      '{REQ_APPEND,    32'sh7fffffff,   1'b0},
      '{REQ_RSVD_6,    32'sh7fffffff,   1'b0},
      '{REQ_DEL_FIRST, 32'sh7fffffff,   1'b0},
      '{REQ_DEL_FIRST, 32'sd42,         1'b0},
      '{REQ_DEL_ALL,   32'sd42,         1'b0},
      '{REQ_RSVD_7,    32'sh80000000,   1'b0},
      '{REQ_DEL_ALL,   32'sh80000000,   1'b0},
      '{REQ_CLEAR,     32'sd0,          1'b1},
      '{REQ_QUERY,     -32'sd1,         1'b1}
   };

   initial begin : req_side
      int n, rsp_goal;
      bit timed_out;
      list_stats_type e;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         send_request(directed_rows[k].op, directed_rows[k].v, 1'b1);
         e = expected_stats[$];
         if (directed_rows[k].check_empty && !(e.is_empty && e.largest == -999 &&
             e.smallest == 9999999 && e.most_frequent == -999 && e.mean == 0))
            report_mismatch("empty-list prediction", 0, 1);
      end

      // fill to capacity and push past it
      for (n = 0; n < CAPACITY + 3; n++) send_request(REQ_APPEND, pick_value(), 1'b1);

      // hold off until every response has drained
      while (expected_stats.size() != 0) @(negedge clock);

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         case ($urandom_range(0, 19))
            0:              send_request(REQ_CLEAR, $urandom, n % 4 != 0);
            1, 2:           send_request(REQ_DEL_ALL, pick_value(), n % 4 != 0);
            3, 4, 5:        send_request(REQ_DEL_FIRST, pick_value(), n % 4 != 0);
            6, 7:           send_request(3'($urandom_range(4, 7)), pick_value(), n % 4 != 0);
            default:        send_request(REQ_APPEND, pick_value(), n % 4 != 0);
         endcase
         if (n == RANDOM_ITEMS / 2)
            while (expected_stats.size() != 0) @(negedge clock);
      end

      rsp_goal = 0;
      while (expected_stats.size() != 0 && rsp_goal < 200000) begin
         @(negedge clock);
         rsp_goal++;
      end
      timed_out = (expected_stats.size() != 0);
      repeat (700) @(posedge clock);
      $display("Covered %0d responses, %0d at full capacity, %0d rejected appends.",
               rsp_seen, full_seen, reject_seen);
      if (!timed_out && error_count == 0 && expected_stats.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #150ms;
      $display("Some tests failed");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/blte_pkg.sv
hw/rtl/blte_ram.sv
hw/rtl/blte_div.sv
hw/rtl/bounded_list_table_engine.sv
tb/tb.sv
